@@ hdl/cme_pkg.sv @@
package cme_pkg;

  // Raw controller sample, one per request
  typedef struct packed {
    logic [7:0] key_bits;
    logic       strum_up_key;
    logic [7:0] axis_z;
    logic [7:0] axis_y;
  } in_item_t;

  // One three-byte MIDI message
  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [7:0] second_data;
    logic       last_of_run;
  } out_item_t;

  localparam int unsigned MaxMsgs = 4;

  // All messages caused by one sample
  typedef struct packed {
    logic [2:0]                    count;
    out_item_t [MaxMsgs-1:0]       msg;
  } run_t;

  typedef struct packed {
    logic [7:0] base_note;
    logic [6:0] note_velocity;
    logic [3:0] midi_channel;
  } cfg_t;

  // Register indexes
  localparam logic [1:0] REG_BASE_NOTE     = 2'd0;
  localparam logic [1:0] REG_NOTE_VELOCITY = 2'd1;
  localparam logic [1:0] REG_MIDI_CHANNEL  = 2'd2;

  localparam logic [7:0]  RESET_BASE_NOTE  = 8'h3c;
  localparam logic [6:0]  RESET_VELOCITY   = 7'h40;
  localparam logic [7:0]  RESET_HELD_PITCH = 8'h3c;

  localparam logic [7:0]  DOWN_STRUM_CODE  = 8'd191;
  localparam logic [7:0]  WHAMMY_ZERO      = 8'd240;
  localparam logic [7:0]  NOTE_STATUS      = 8'h90;
  localparam logic [7:0]  BEND_STATUS      = 8'hE0;
  localparam logic [15:0] BEND_CENTER      = 16'h4000;

endpackage

@@ hdl/controller_to_midi_events_top.sv @@
// Controller sample to MIDI message converter. Each accepted request is one
// polled controller sample (key byte, strum-up switch, z and y axis bytes);
// it yields zero to four three-byte MIDI messages, in the order strum-down
// note-on or note-off, strum-up note-on/note-off pair, pitch bend, with
// last_of_run set on the final one. A sample sits in an input register while
// its messages are decoded into a run buffer; the run buffer then hands out
// one message per cycle while out_stall is low. A new sample is taken every
// cycle while the run buffer keeps up; a sample with several messages holds
// the next one in the input register until its run drains, so the sustained
// rate is set by the one-message-per-cycle output port. The configuration
// port is always ready; write only while no sample is in flight. Indexes past
// the register list are ignored.
module controller_to_midi_events_top import cme_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // sample channel
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  // message channel
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t cfg;
  run_t run;
  logic run_ready;
  logic run_take;

  assign cfg_ready = 1'b1;

  // configuration registers; writes take effect on the next sample
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_note     <= RESET_BASE_NOTE;
      cfg.note_velocity <= RESET_VELOCITY;
      cfg.midi_channel  <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_NOTE:     cfg.base_note     <= cfg_data;
        REG_NOTE_VELOCITY: cfg.note_velocity <= cfg_data[6:0];
        REG_MIDI_CHANNEL:  cfg.midi_channel  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // sample register, edge detection, octave and pitch state
  cme_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .run_ready (run_ready),
    .run_take  (run_take),
    .run       (run)
  );

  // run buffer, one message out per cycle while out_stall is low
  cme_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .run_take  (run_take),
    .run       (run),
    .run_ready (run_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  // a run is only loaded once the previous one has fully drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    run_take |-> !out_valid || (!out_stall && out_item.last_of_run))
    else $error("run buffer overwritten with messages pending");
`endif

endmodule

@@ hdl/cme_decode.sv @@
module cme_decode import cme_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     run_ready,
  output logic     run_take,
  output run_t     run
);

  in_item_t   in_reg;
  logic       in_full;
  logic       in_accept;

  logic       prev_sdown;
  logic       prev_strum_up;
  logic       prev_plus;
  logic       prev_minus;
  logic [7:0] prev_whammy;
  logic [7:0] octave_offset;
  logic [7:0] held_pitch;

  logic       sdown, plus, minus;
  logic [7:0] whammy;
  logic [4:0] fret;
  logic [7:0] octave_next;
  logic [7:0] pitch;
  logic       sd_rise, sd_fall, su_rise;
  logic [7:0] note_st, bend_st;
  logic [15:0] bend;

  assign run_take  = in_full && run_ready;
  assign in_stall  = in_full && !run_ready;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (run_take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_reg <= in_item;
    end
  end

  // Decode of the held sample
  always_comb begin
    sdown   = (in_reg.axis_z == DOWN_STRUM_CODE);
    plus    = ~in_reg.axis_z[2];
    minus   = ~in_reg.axis_z[4];
    whammy  = in_reg.axis_y - WHAMMY_ZERO;
    fret    = {in_reg.key_bits[7], in_reg.key_bits[5], in_reg.key_bits[3],
               in_reg.key_bits[6], in_reg.key_bits[4]};
    octave_next = octave_offset + {7'd0, plus & ~prev_plus}
                                - {7'd0, minus & ~prev_minus};
    // 12 * offset as two shifts
    pitch   = cfg.base_note + {3'd0, fret} + {octave_next[4:0], 3'd0}
                            + {octave_next[5:0], 2'd0};
    sd_rise = sdown & ~prev_sdown;
    sd_fall = ~sdown & prev_sdown;
    su_rise = in_reg.strum_up_key & ~prev_strum_up;
    note_st = NOTE_STATUS | {4'd0, cfg.midi_channel};
    bend_st = BEND_STATUS | {4'd0, cfg.midi_channel};
    bend    = BEND_CENTER + {whammy[5:0], 10'd0};
  end

  // Message list in order: strum-down, strum-up pair, bend
  always_comb begin
    run = '0;
    if (sd_rise) begin
      run.msg[run.count[1:0]] = '{note_st, pitch, {1'b0, cfg.note_velocity}, 1'b0};
      run.count = run.count + 3'd1;
    end else if (sd_fall) begin
      run.msg[run.count[1:0]] = '{note_st, held_pitch, 8'd0, 1'b0};
      run.count = run.count + 3'd1;
    end
    if (su_rise) begin
      run.msg[run.count[1:0]] = '{note_st, pitch, {1'b0, cfg.note_velocity}, 1'b0};
      run.count = run.count + 3'd1;
      run.msg[run.count[1:0]] = '{note_st, pitch, 8'd0, 1'b0};
      run.count = run.count + 3'd1;
    end
    if (whammy != prev_whammy) begin
      run.msg[run.count[1:0]] = '{bend_st, bend[7:0], bend[15:8], 1'b0};
      run.count = run.count + 3'd1;
    end
    if (run.count != 3'd0) begin
      run.msg[run.count[1:0] - 2'd1].last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sdown      <= 1'b0;
      prev_strum_up   <= 1'b0;
      prev_plus       <= 1'b0;
      prev_minus      <= 1'b0;
      prev_whammy     <= 8'd0;
      octave_offset   <= 8'd0;
      held_pitch      <= RESET_HELD_PITCH;
    end else if (run_take) begin
      prev_sdown      <= sdown;
      prev_strum_up   <= in_reg.strum_up_key;
      prev_plus       <= plus;
      prev_minus      <= minus;
      prev_whammy     <= whammy;
      octave_offset   <= octave_next;
      if (sd_rise || su_rise) begin
        held_pitch <= pitch;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A held sample waits until the run buffer frees up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && !run_ready |=> in_full && $stable(in_reg))
    else $error("sample lost while run buffer busy");

  // Never more than four messages per sample
  a_count: assert property (@(posedge clk) disable iff (rst)
    in_full |-> run.count <= 3'd4)
    else $error("message count overflow");
`endif

endmodule

@@ hdl/cme_serializer.sv @@
module cme_serializer import cme_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      run_take,
  input  run_t      run,
  output logic      run_ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  out_item_t [MaxMsgs-1:0] run_msg;
  logic [2:0]              run_count;
  logic [1:0]              run_idx;
  logic                    out_accept;
  logic                    at_last;

  assign out_valid  = (run_count != 3'd0);
  assign out_item   = run_msg[run_idx];
  assign out_accept = out_valid && !out_stall;
  assign at_last    = ({1'b0, run_idx} == run_count - 3'd1);
  assign run_ready  = !out_valid || (out_accept && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= 3'd0;
      run_idx   <= 2'd0;
    end else if (run_take) begin
      run_count <= run.count;
      run_idx   <= 2'd0;
    end else if (out_accept) begin
      if (at_last) begin
        run_count <= 3'd0;
        run_idx   <= 2'd0;
      end else begin
        run_idx <= run_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_take) begin
      run_msg <= run.msg;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, run_idx} < run_count)
    else $error("run index past message count");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && at_last |-> out_item.last_of_run)
    else $error("final message of run not marked");
`endif

endmodule
